// ===== rtl/core/free_chunk_table_assert.svh =====
// Assertion macros for the free chunk table.
// Included by modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef FREE_CHUNK_TABLE_ASSERT_SVH
`define FREE_CHUNK_TABLE_ASSERT_SVH

// same-cycle implication
`define FCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fct_pkg.sv =====
// Shared types and constants for the free chunk table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fct_pkg;

	localparam int CAPACITY_DEF     = 64;
	localparam int ADDRESS_BITS_DEF = 48;

	localparam int ADDR_W      = 48;
	localparam int LEN_W       = 32;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 3;
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 88;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE,
		S_FETCH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    valid;
		status_t status;
	} fct_res_t;

endpackage

// ===== rtl/core/fct_mem.sv =====
// Single-port-write, single-port-read slot store with registered read data.
// Holds chunk address and length per slot; uses fct_pkg.
`timescale 1ns / 1ps

module fct_mem import fct_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int IW    = $clog2(CAPACITY_DEF),
	parameter int DW    = ADDRESS_BITS_DEF + LEN_W
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [DW-1:0] wdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/fct_ctrl.sv =====
// Sequencer for the free chunk table: linear address scan through one comparator,
// swap-remove, append, indexed read and clear. Uses fct_pkg and the assert macros.
`timescale 1ns / 1ps

`include "free_chunk_table_assert.svh"

module fct_ctrl import fct_pkg::*; #(
	parameter int CAPACITY     = CAPACITY_DEF,
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
	parameter int IW           = $clog2(CAPACITY_DEF),
	parameter int CW           = $clog2(CAPACITY_DEF + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  op_t                     in_op,
	input  logic [ADDRESS_BITS-1:0] in_addr,
	input  logic [LEN_W-1:0]        in_len,
	input  logic [IDX_W-1:0]        in_idx,
	output fct_res_t                res,
	output logic [ADDRESS_BITS-1:0] res_addr,
	output logic [LEN_W-1:0]        res_len,
	output logic [CW-1:0]           res_cnt,
	input  logic                    res_take,
	output logic                    rd_en,
	output logic [IW-1:0]           rd_addr,
	input  logic [ADDRESS_BITS-1:0] rd_data_addr,
	input  logic [LEN_W-1:0]        rd_data_len,
	output logic                    we,
	output logic [IW-1:0]           waddr,
	output logic [ADDRESS_BITS-1:0] wdata_addr,
	output logic [LEN_W-1:0]        wdata_len
);

	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

	state_t                  state_q, state_n;
	op_t                     op_q;
	status_t                 status_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic [LEN_W-1:0]        len_q;
	logic [CW-1:0]           ptr_q;
	logic [CW-1:0]           cnt_q;
	logic                    chk_q;
	logic [IW-1:0]           cmp_q;
	logic [IW-1:0]           pos_q;
	logic [ADDRESS_BITS-1:0] raddr_q;
	logic [LEN_W-1:0]        rlen_q;

	logic                    match;
	logic                    scan_end;
	logic                    full;
	logic                    idx_bad;
	logic [CW-1:0]           cnt_m1;
	logic [IW-1:0]           last_idx;
	logic [CMPW-1:0]         idx_ext;
	logic [CMPW-1:0]         cnt_ext;

	// shared comparator: stored address against the key
	assign match    = chk_q && (rd_data_addr == addr_q);
	assign scan_end = (ptr_q >= cnt_q);
	assign full     = (cnt_q >= CW'(CAPACITY));
	assign cnt_m1   = cnt_q - CW'(1);
	assign last_idx = cnt_m1[IW-1:0];
	assign idx_ext  = CMPW'(in_idx);
	assign cnt_ext  = CMPW'(cnt_q);
	assign idx_bad  = (idx_ext >= cnt_ext);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_op)
						OP_ADD:    state_n = full ? S_DONE : S_SCAN;
						OP_REMOVE: state_n = S_SCAN;
						OP_READ:   state_n = idx_bad ? S_DONE : S_FETCH;
						OP_CLEAR:  state_n = S_DONE;
						default:   state_n = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (match) begin
					state_n = (op_q == OP_REMOVE && cmp_q != last_idx) ? S_MOVE : S_DONE;
				end else if (scan_end) begin
					state_n = S_DONE;
				end
			end
			S_MOVE:  state_n = S_DONE;
			S_FETCH: state_n = S_DONE;
			S_DONE: begin
				if (res_take) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = ptr_q[IW-1:0];
		we         = 1'b0;
		waddr      = cnt_q[IW-1:0];
		wdata_addr = addr_q;
		wdata_len  = len_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = idx_ext[IW-1:0];
				rd_en    = in_valid && (in_op == OP_READ);
			end
			S_SCAN: begin
				if (match && op_q == OP_REMOVE) begin
					rd_en   = 1'b1;
					rd_addr = last_idx;
				end else begin
					rd_en = !scan_end;
				end
				if (!match && scan_end && op_q == OP_ADD) begin
					we = 1'b1;
				end
			end
			S_MOVE: begin
				we         = 1'b1;
				waddr      = pos_q;
				wdata_addr = rd_data_addr;
				wdata_len  = rd_data_len;
			end
			S_FETCH, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			chk_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= in_op;
						addr_q   <= in_addr;
						len_q    <= in_len;
						ptr_q    <= '0;
						chk_q    <= 1'b0;
						status_q <= ST_OK;
						raddr_q  <= '0;
						rlen_q   <= '0;
						unique case (in_op)
							OP_ADD: begin
								if (full) begin
									status_q <= ST_FULL;
								end
							end
							OP_READ: begin
								if (idx_bad) begin
									status_q <= ST_RANGE;
								end
							end
							OP_CLEAR: cnt_q <= '0;
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					chk_q <= !scan_end;
					cmp_q <= ptr_q[IW-1:0];
					if (!scan_end) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (match) begin
						if (op_q == OP_ADD) begin
							status_q <= ST_DUPLICATE;
						end else begin
							pos_q <= cmp_q;
							cnt_q <= cnt_m1;
						end
					end else if (scan_end) begin
						if (op_q == OP_ADD) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							status_q <= ST_NOT_FOUND;
						end
					end
				end
				S_FETCH: begin
					raddr_q <= rd_data_addr;
					rlen_q  <= rd_data_len;
				end
				S_MOVE, S_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign res.valid  = (state_q == S_DONE);
	assign res.status = status_q;
	assign res_addr   = raddr_q;
	assign res_len    = rlen_q;
	assign res_cnt    = cnt_q;

	`FCT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(CAPACITY), "count above capacity")
	`FCT_ASSERT_NOW(a_move_inside, state_q == S_MOVE, CW'(pos_q) < cnt_q, "move target outside table")
	`FCT_ASSERT_NEXT(a_done_hold, state_q == S_DONE, $stable(cnt_q), "count moved while result pending")

endmodule

// ===== rtl/core/free_chunk_table.sv =====
// Free chunk table top level: beat capture, output register and instances.
// Depends on fct_pkg, fct_ctrl and fct_mem.
//
//  channel | dir | handshake        | payload
//  s       | in  | s_tvalid/tready  | tuser: opcode; tdata: address, length, index
//  m       | out | m_tvalid/tready  | tuser: status; tdata: address, length, count
//
// Add and remove scan the used slots through one address comparator, one slot per cycle,
// stopping at a match; an add to a full table does not scan.
// s_tready is high only between items; a finished result waits in the output register.
// Reset clears the count and control only; slot contents are unknown until written.
`timescale 1ns / 1ps

module free_chunk_table import fct_pkg::*; #(
	parameter int CAPACITY     = CAPACITY_DEF,
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // chunk_address, chunk_length, entry_index, pad
	input  logic [OP_W-1:0]        s_tuser,  // opcode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // read_address, read_length, entry_count, pad
	output logic [STATUS_W-1:0]    m_tuser   // status
);

	localparam int IW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int AWIDE = (ADDRESS_BITS > ADDR_W) ? ADDRESS_BITS : ADDR_W;
	localparam int CWIDE = (CW > CNT_W) ? CW : CNT_W;
	localparam int DW    = ADDRESS_BITS + LEN_W;

	fct_res_t                res;
	logic                    res_take;
	logic [AWIDE-1:0]        in_wide;
	logic [AWIDE-1:0]        out_wide;
	logic [CWIDE-1:0]        cnt_wide;
	logic [ADDRESS_BITS-1:0] res_addr;
	logic [LEN_W-1:0]        res_len;
	logic [CW-1:0]           res_cnt;

	logic                    rd_en;
	logic [IW-1:0]           rd_addr;
	logic [DW-1:0]           rd_data;
	logic                    we;
	logic [IW-1:0]           waddr;
	logic [ADDRESS_BITS-1:0] wdata_addr;
	logic [LEN_W-1:0]        wdata_len;

	logic                    m_tvalid_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;
	logic [STATUS_W-1:0]     m_tuser_q;

	assign in_wide  = AWIDE'(s_tdata[ADDR_W-1:0]);
	assign out_wide = AWIDE'(res_addr);
	assign cnt_wide = CWIDE'(res_cnt);
	assign res_take = !m_tvalid_q || m_tready;

	fct_ctrl #(
		.CAPACITY     (CAPACITY),
		.ADDRESS_BITS (ADDRESS_BITS),
		.IW           (IW),
		.CW           (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (op_t'(s_tuser)),
		.in_addr      (in_wide[ADDRESS_BITS-1:0]),
		.in_len       (s_tdata[ADDR_W +: LEN_W]),
		.in_idx       (s_tdata[ADDR_W + LEN_W +: IDX_W]),
		.res          (res),
		.res_addr     (res_addr),
		.res_len      (res_len),
		.res_cnt      (res_cnt),
		.res_take     (res_take),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data_addr (rd_data[DW-1:LEN_W]),
		.rd_data_len  (rd_data[LEN_W-1:0]),
		.we           (we),
		.waddr        (waddr),
		.wdata_addr   (wdata_addr),
		.wdata_len    (wdata_len)
	);

	fct_mem #(
		.DEPTH   (CAPACITY),
		.IW      (IW),
		.DW      (DW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.we      (we),
		.waddr   (waddr),
		.wdata   ({wdata_addr, wdata_len})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_take) begin
			m_tdata_q <= OUT_TDATA_W'({cnt_wide[CNT_W-1:0], res_len, out_wide[ADDR_W-1:0]});
			m_tuser_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
